// ----- rtl/amstore_pkg.sv -----
`timescale 1ns / 1ps

package amstore_pkg;

   // request function codes
   localparam logic [2:0] FUNC_SET_EDGE   = 3'd0;
   localparam logic [2:0] FUNC_CLEAR_EDGE = 3'd1;
   localparam logic [2:0] FUNC_READ_EDGE  = 3'd2;
   localparam logic [2:0] FUNC_ADJ_TEST   = 3'd3;
   localparam logic [2:0] FUNC_ROW_STREAM = 3'd4;
   localparam logic [2:0] FUNC_INSERT     = 3'd5;
   localparam logic [2:0] FUNC_DELETE     = 3'd6;

   // response status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // most elements one row stream returns
   localparam int STREAM_LIMIT = 16;

   localparam int WEIGHT_WIDTH = 32;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WR1,
      ST_WR2,
      ST_RESP,
      ST_RD,
      ST_RD_OUT,
      ST_ROW_RD,
      ST_ROW_OUT,
      ST_MV_RD,
      ST_MV_WR
   } state_type;

endpackage

// ----- rtl/amstore_ram.sv -----
`timescale 1ns / 1ps

module amstore_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/adjacency_matrix_store_unit.sv -----
`timescale 1ns / 1ps

// channel   direction  handshake                     payload
// req_      in         req_valid / req_ready         func, row_vertex, col_vertex,
//                                                    vertex_label, edge_weight
// rsp_      out        rsp_valid / rsp_ready         status, weight_out, is_adjacent,
//                                                    column_index, vertex_total, last
// csr_      in         csr_write_enable (no wait)    csr_write_data = directed_mode
//
// a request is taken only in idle; edge read/test reads one ram word, edge set/clear writes one or two
// (mirrored write), row stream reads one word per column, insert/delete moves every cell of
// the new square, (n+1)^2 cells for insert or n^2 for delete, all through the one matrix ram port pair
// after reset a clearing pass writes zero to all 2^(2*clog2(MAX_VERTICES)) ram words,
// one a cycle, and no request is taken meanwhile (256 words at the default)
// a result waiting in the output register stalls the sequencer only where it needs to
// send the next word; the next request is taken while the last word still waits

module adjacency_matrix_store_unit #(
   parameter int MAX_VERTICES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [3:0]  req_row_vertex,
   input  logic [3:0]  req_col_vertex,
   input  logic [4:0]  req_vertex_label,
   input  logic signed [31:0] req_edge_weight,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic signed [31:0] rsp_weight_out,
   output logic        rsp_is_adjacent,
   output logic [3:0]  rsp_column_index,
   output logic [4:0]  rsp_vertex_total,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);

   localparam int VW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int AW    = 2 * VW;
   localparam int DEPTH = 1 << AW;
   localparam int CW    = $clog2(MAX_VERTICES + 1);
   localparam int CMPW  = (CW > 5) ? CW : 5;
   localparam int WW    = amstore_pkg::WEIGHT_WIDTH;

   amstore_pkg::state_type state_ff, state_in;

   logic [2:0]    func_ff, func_in;
   logic [3:0]    row_ff, row_in;
   logic [3:0]    col_ff, col_in;
   logic [4:0]    label_ff, label_in;
   logic [WW-1:0] weight_ff, weight_in;
   logic [1:0]    status_ff, status_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          directed_ff, directed_in;
   logic [VW-1:0] ii_ff, ii_in;
   logic [VW-1:0] jj_ff, jj_in;
   logic [VW-1:0] lim_ff, lim_in;
   logic          ins_ff, ins_in;
   logic [3:0]    kk_ff, kk_in;
   logic [AW-1:0] clr_ff, clr_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [WW-1:0] rsp_weight_ff, rsp_weight_in;
   logic          rsp_adj_ff, rsp_adj_in;
   logic [3:0]    rsp_col_ff, rsp_col_in;
   logic [4:0]    rsp_total_ff, rsp_total_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [WW-1:0] ram_wdata, ram_rdata;

   logic            out_free;
   logic [CMPW-1:0] n_ext;
   logic            edge_ok, lbl_lt, lbl_le, full;
   logic [CMPW-1:0] stream_cnt;
   logic            row_last;
   logic [VW-1:0]   lbl_v;
   logic            mv_zero, mv_done;
   logic [VW-1:0]   src_i, src_j;

   amstore_ram #(
      .WIDTH(WW),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign n_ext    = CMPW'(cnt_ff);
   assign edge_ok  = (CMPW'(req_row_vertex) < n_ext) && (CMPW'(req_col_vertex) < n_ext);
   assign lbl_lt   = CMPW'(req_vertex_label) < n_ext;
   assign lbl_le   = CMPW'(req_vertex_label) <= n_ext;
   assign full     = n_ext >= CMPW'(MAX_VERTICES);

   assign stream_cnt = (n_ext < CMPW'(amstore_pkg::STREAM_LIMIT)) ?
                       n_ext : CMPW'(amstore_pkg::STREAM_LIMIT);
   assign row_last   = (CMPW'(kk_ff) + CMPW'(1)) == stream_cnt;

   // insert walks the new square bottom-up so each source is read before it is overwritten,
   // delete walks top-down for the same reason
   assign lbl_v = VW'(label_ff);
   always_comb begin
      if (ins_ff) begin
         mv_zero = (ii_ff == lbl_v) || (jj_ff == lbl_v);
         src_i   = (ii_ff > lbl_v) ? ii_ff - VW'(1) : ii_ff;
         src_j   = (jj_ff > lbl_v) ? jj_ff - VW'(1) : jj_ff;
         mv_done = (ii_ff == '0) && (jj_ff == '0);
      end else begin
         mv_zero = (ii_ff == lim_ff) || (jj_ff == lim_ff);
         src_i   = (ii_ff >= lbl_v) ? ii_ff + VW'(1) : ii_ff;
         src_j   = (jj_ff >= lbl_v) ? jj_ff + VW'(1) : jj_ff;
         mv_done = (ii_ff == lim_ff) && (jj_ff == lim_ff);
      end
   end

   assign directed_in = csr_write_enable ? csr_write_data : directed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= amstore_pkg::ST_CLEAR;
         cnt_ff       <= '0;
         directed_ff  <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         directed_ff  <= directed_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      label_ff      <= label_in;
      weight_ff     <= weight_in;
      status_ff     <= status_in;
      ii_ff         <= ii_in;
      jj_ff         <= jj_in;
      lim_ff        <= lim_in;
      ins_ff        <= ins_in;
      kk_ff         <= kk_in;
      rsp_status_ff <= rsp_status_in;
      rsp_weight_ff <= rsp_weight_in;
      rsp_adj_ff    <= rsp_adj_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      label_in      = label_ff;
      weight_in     = weight_ff;
      status_in     = status_ff;
      cnt_in        = cnt_ff;
      ii_in         = ii_ff;
      jj_in         = jj_ff;
      lim_in        = lim_ff;
      ins_in        = ins_ff;
      kk_in         = kk_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_weight_in = rsp_weight_ff;
      rsp_adj_in    = rsp_adj_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_last_in   = rsp_last_ff;
      req_ready     = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = {VW'(row_ff), VW'(col_ff)};
      ram_wdata     = '0;
      ram_re        = 1'b0;
      ram_raddr     = {VW'(row_ff), VW'(col_ff)};

      unique case (state_ff)
         amstore_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == {AW{1'b1}}) begin
               state_in = amstore_pkg::ST_IDLE;
            end
         end
         amstore_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               func_in   = req_func;
               row_in    = req_row_vertex;
               col_in    = req_col_vertex;
               label_in  = req_vertex_label;
               weight_in = req_edge_weight;
               kk_in     = '0;
               status_in = amstore_pkg::STATUS_OK;
               state_in  = amstore_pkg::ST_RESP;
               unique case (req_func) inside
                  amstore_pkg::FUNC_SET_EDGE, amstore_pkg::FUNC_CLEAR_EDGE: begin
                     if (edge_ok) begin
                        state_in = amstore_pkg::ST_WR1;
                     end else begin
                        status_in = amstore_pkg::STATUS_RANGE;
                     end
                  end
                  amstore_pkg::FUNC_READ_EDGE, amstore_pkg::FUNC_ADJ_TEST: begin
                     if (edge_ok) begin
                        state_in = amstore_pkg::ST_RD;
                     end else begin
                        status_in = amstore_pkg::STATUS_RANGE;
                     end
                  end
                  amstore_pkg::FUNC_ROW_STREAM: begin
                     if (lbl_lt) begin
                        state_in = amstore_pkg::ST_ROW_RD;
                     end else begin
                        status_in = amstore_pkg::STATUS_RANGE;
                     end
                  end
                  amstore_pkg::FUNC_INSERT: begin
                     if (!lbl_le) begin
                        status_in = amstore_pkg::STATUS_RANGE;
                     end else if (full) begin
                        status_in = amstore_pkg::STATUS_FULL;
                     end else begin
                        ii_in    = VW'(cnt_ff);
                        jj_in    = VW'(cnt_ff);
                        lim_in   = VW'(cnt_ff);
                        ins_in   = 1'b1;
                        state_in = amstore_pkg::ST_MV_RD;
                     end
                  end
                  amstore_pkg::FUNC_DELETE: begin
                     if (lbl_lt) begin
                        ii_in    = '0;
                        jj_in    = '0;
                        lim_in   = VW'(cnt_ff - CW'(1));
                        ins_in   = 1'b0;
                        state_in = amstore_pkg::ST_MV_RD;
                     end else begin
                        status_in = amstore_pkg::STATUS_RANGE;
                     end
                  end
                  default: begin
                     status_in = amstore_pkg::STATUS_OK;
                  end
               endcase
            end
         end
         amstore_pkg::ST_WR1: begin
            ram_we    = 1'b1;
            ram_wdata = (func_ff == amstore_pkg::FUNC_CLEAR_EDGE) ? '0 : weight_ff;
            // undirected graphs mirror to the transposed entry, self loops once
            if (!directed_ff && (row_ff != col_ff)) begin
               state_in = amstore_pkg::ST_WR2;
            end else begin
               state_in = amstore_pkg::ST_RESP;
            end
         end
         amstore_pkg::ST_WR2: begin
            ram_we    = 1'b1;
            ram_waddr = {VW'(col_ff), VW'(row_ff)};
            ram_wdata = (func_ff == amstore_pkg::FUNC_CLEAR_EDGE) ? '0 : weight_ff;
            state_in  = amstore_pkg::ST_RESP;
         end
         amstore_pkg::ST_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_weight_in = '0;
               rsp_adj_in    = 1'b0;
               rsp_col_in    = '0;
               rsp_total_in  = 5'(cnt_ff);
               rsp_last_in   = 1'b1;
               state_in      = amstore_pkg::ST_IDLE;
            end
         end
         amstore_pkg::ST_RD: begin
            ram_re   = 1'b1;
            state_in = amstore_pkg::ST_RD_OUT;
         end
         amstore_pkg::ST_RD_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = amstore_pkg::STATUS_OK;
               rsp_weight_in = ram_rdata;
               rsp_adj_in    = ram_rdata != '0;
               rsp_col_in    = '0;
               rsp_total_in  = 5'(cnt_ff);
               rsp_last_in   = 1'b1;
               state_in      = amstore_pkg::ST_IDLE;
            end
         end
         amstore_pkg::ST_ROW_RD: begin
            ram_re    = 1'b1;
            ram_raddr = {VW'(label_ff), VW'(kk_ff)};
            state_in  = amstore_pkg::ST_ROW_OUT;
         end
         amstore_pkg::ST_ROW_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = amstore_pkg::STATUS_OK;
               rsp_weight_in = ram_rdata;
               rsp_adj_in    = ram_rdata != '0;
               rsp_col_in    = kk_ff;
               rsp_total_in  = 5'(cnt_ff);
               rsp_last_in   = row_last;
               kk_in         = kk_ff + 4'd1;
               state_in      = row_last ? amstore_pkg::ST_IDLE : amstore_pkg::ST_ROW_RD;
            end
         end
         amstore_pkg::ST_MV_RD: begin
            ram_re    = !mv_zero;
            ram_raddr = {src_i, src_j};
            state_in  = amstore_pkg::ST_MV_WR;
         end
         amstore_pkg::ST_MV_WR: begin
            ram_we    = 1'b1;
            ram_waddr = {ii_ff, jj_ff};
            ram_wdata = mv_zero ? '0 : ram_rdata;
            state_in  = amstore_pkg::ST_MV_RD;
            if (mv_done) begin
               cnt_in    = ins_ff ? cnt_ff + CW'(1) : cnt_ff - CW'(1);
               status_in = amstore_pkg::STATUS_OK;
               state_in  = amstore_pkg::ST_RESP;
            end else if (ins_ff) begin
               if (jj_ff == '0) begin
                  ii_in = ii_ff - VW'(1);
                  jj_in = lim_ff;
               end else begin
                  jj_in = jj_ff - VW'(1);
               end
            end else begin
               if (jj_ff == lim_ff) begin
                  ii_in = ii_ff + VW'(1);
                  jj_in = '0;
               end else begin
                  jj_in = jj_ff + VW'(1);
               end
            end
         end
         default: begin
            state_in = amstore_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_weight_out   = rsp_weight_ff;
   assign rsp_is_adjacent  = rsp_adj_ff;
   assign rsp_column_index = rsp_col_ff;
   assign rsp_vertex_total = rsp_total_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef SYNTHESIS
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == amstore_pkg::ST_CLEAR) |-> !req_ready)
      else $error("request taken during clearing pass");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMPW'(cnt_ff) <= CMPW'(MAX_VERTICES))
      else $error("live vertex count above capacity");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == amstore_pkg::ST_IDLE) |-> !ram_we)
      else $error("matrix written while idle");

   a_move_read_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == amstore_pkg::ST_MV_RD) |-> !ram_we)
      else $error("write during move read cycle");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != amstore_pkg::ST_MV_WR) |=> (cnt_ff == $past(cnt_ff)))
      else $error("vertex count changed outside a move");
`endif

endmodule

// ----- tb/adjacency_matrix_store_unit_tb.sv -----
`timescale 1ns / 1ps

module adjacency_matrix_store_unit_tb;

   localparam logic [2:0] FUNC_UNUSED = 3'd7;
   localparam int unsigned NV = 16;

   typedef struct packed {
      logic [2:0]  func;
      logic [3:0]  row;
      logic [3:0]  col;
      logic [4:0]  label;
      logic [31:0] weight;
   } request_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] weight;
      logic        adjacent;
      logic [3:0]  column;
      logic [4:0]  total;
      logic        last;
   } response_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [3:0]  row;
      logic [3:0]  col;
      logic [4:0]  label;
      logic [31:0] weight;
      logic        typed;
      logic [1:0]  status;
      logic [4:0]  total;
   } directed_row_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [2:0]         req_func;
   logic [3:0]         req_row_vertex;
   logic [3:0]         req_col_vertex;
   logic [4:0]         req_vertex_label;
   logic signed [31:0] req_edge_weight;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_weight_out;
   logic               rsp_is_adjacent;
   logic [3:0]         rsp_column_index;
   logic [4:0]         rsp_vertex_total;
   logic               rsp_last;
   logic               csr_write_enable;
   logic               csr_write_data;

   // shadow copy of the graph
   logic [31:0]  graph_weight [0:NV-1][0:NV-1];
   int unsigned  graph_order;
   logic         graph_directed;

   response_type     awaited_words[$];
   directed_row_type dir_table [0:25];

   int unsigned  req_idle_pct = 13;
   int unsigned  rsp_idle_pct = 13;
   int unsigned  requests_sent = 0;
   int unsigned  words_checked = 0;
   int unsigned  mismatches = 0;
   int unsigned  range_words = 0;
   int unsigned  full_words = 0;

   int unsigned  phase_target [0:3] = '{16, 6, 12, 16};
   logic         phase_mode   [0:3] = '{1'b1, 1'b0, 1'b1, 1'b0};
   int unsigned  phase_items  [0:3] = '{115, 110, 105, 115};
   int unsigned  phase_idle   [0:3] = '{13, 0, 13, 13};

   adjacency_matrix_store_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_row_vertex   (req_row_vertex),
      .req_col_vertex   (req_col_vertex),
      .req_vertex_label (req_vertex_label),
      .req_edge_weight  (req_edge_weight),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_weight_out   (rsp_weight_out),
      .rsp_is_adjacent  (rsp_is_adjacent),
      .rsp_column_index (rsp_column_index),
      .rsp_vertex_total (rsp_vertex_total),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic response_type make_word(input logic [1:0] st, input logic [31:0] w,
                                              input logic [3:0] col, input logic lst);
      response_type rw;
      rw.status   = st;
      rw.weight   = w;
      rw.adjacent = (w != 32'd0);
      rw.column   = col;
      rw.total    = 5'(graph_order);
      rw.last     = lst;
      return rw;
   endfunction

   // updates the shadow graph and lists the words the request should return
   function automatic void apply_request(input request_type rq, ref response_type words[$]);
      int unsigned n;
      int unsigned lbl;
      logic        edge_ok;
      logic [31:0] w;
      n = graph_order;
      lbl = rq.label;
      w = rq.weight;
      edge_ok = (rq.row < n) && (rq.col < n);
      case (rq.func)
         amstore_pkg::FUNC_SET_EDGE, amstore_pkg::FUNC_CLEAR_EDGE: begin
            if (!edge_ok) begin
               words.push_back(make_word(amstore_pkg::STATUS_RANGE, 32'd0, 4'd0, 1'b1));
            end else begin
               if (rq.func == amstore_pkg::FUNC_CLEAR_EDGE) w = 32'd0;
               graph_weight[rq.row][rq.col] = w;
               if (!graph_directed) graph_weight[rq.col][rq.row] = w;
               words.push_back(make_word(amstore_pkg::STATUS_OK, 32'd0, 4'd0, 1'b1));
            end
         end
         amstore_pkg::FUNC_READ_EDGE, amstore_pkg::FUNC_ADJ_TEST: begin
            if (!edge_ok)
               words.push_back(make_word(amstore_pkg::STATUS_RANGE, 32'd0, 4'd0, 1'b1));
            else
               words.push_back(make_word(amstore_pkg::STATUS_OK,
                                         graph_weight[rq.row][rq.col], 4'd0, 1'b1));
         end
         amstore_pkg::FUNC_ROW_STREAM: begin
            if (lbl >= n) begin
               words.push_back(make_word(amstore_pkg::STATUS_RANGE, 32'd0, 4'd0, 1'b1));
            end else begin
               for (int k = 0; k < n; k++)
                  words.push_back(make_word(amstore_pkg::STATUS_OK, graph_weight[lbl][k],
                                            4'(k), (k + 1) == n));
            end
         end
         amstore_pkg::FUNC_INSERT: begin
            if (lbl > n) begin
               words.push_back(make_word(amstore_pkg::STATUS_RANGE, 32'd0, 4'd0, 1'b1));
            end else if (n >= NV) begin
               words.push_back(make_word(amstore_pkg::STATUS_FULL, 32'd0, 4'd0, 1'b1));
            end else begin
               for (int r = n; r > lbl; r--)
                  for (int c = 0; c < NV; c++) graph_weight[r][c] = graph_weight[r-1][c];
               for (int c = 0; c < NV; c++) graph_weight[lbl][c] = 32'd0;
               for (int r = 0; r <= n; r++) begin
                  for (int c = n; c > lbl; c--) graph_weight[r][c] = graph_weight[r][c-1];
                  graph_weight[r][lbl] = 32'd0;
               end
               graph_order = n + 1;
               words.push_back(make_word(amstore_pkg::STATUS_OK, 32'd0, 4'd0, 1'b1));
            end
         end
         amstore_pkg::FUNC_DELETE: begin
            if (lbl >= n) begin
               words.push_back(make_word(amstore_pkg::STATUS_RANGE, 32'd0, 4'd0, 1'b1));
            end else begin
               for (int r = lbl; r + 1 < n; r++)
                  for (int c = 0; c < NV; c++) graph_weight[r][c] = graph_weight[r+1][c];
               for (int c = 0; c < NV; c++) graph_weight[n-1][c] = 32'd0;
               for (int r = 0; r < n; r++) begin
                  for (int c = lbl; c + 1 < n; c++) graph_weight[r][c] = graph_weight[r][c+1];
                  graph_weight[r][n-1] = 32'd0;
               end
               graph_order = n - 1;
               words.push_back(make_word(amstore_pkg::STATUS_OK, 32'd0, 4'd0, 1'b1));
            end
         end
         default: words.push_back(make_word(amstore_pkg::STATUS_OK, 32'd0, 4'd0, 1'b1));
      endcase
   endfunction

   // drifts the vertex count toward target, mostly with in-range indexes
   function automatic request_type random_request(input int unsigned target);
      request_type rq;
      int unsigned n;
      int unsigned ins_w;
      int unsigned del_w;
      int unsigned p;
      int unsigned q;
      n = graph_order;
      if (n < target) begin
         ins_w = 45;
         del_w = 3;
      end else if (n > target) begin
         ins_w = 3;
         del_w = 45;
      end else begin
         ins_w = 15;
         del_w = 15;
      end
      p = $urandom_range(99);
      if (p < ins_w) begin
         rq.func = amstore_pkg::FUNC_INSERT;
      end else if (p < ins_w + del_w) begin
         rq.func = amstore_pkg::FUNC_DELETE;
      end else begin
         q = $urandom_range(99);
         if (q < 40)      rq.func = amstore_pkg::FUNC_SET_EDGE;
         else if (q < 50) rq.func = amstore_pkg::FUNC_CLEAR_EDGE;
         else if (q < 70) rq.func = amstore_pkg::FUNC_READ_EDGE;
         else if (q < 85) rq.func = amstore_pkg::FUNC_ADJ_TEST;
         else             rq.func = amstore_pkg::FUNC_ROW_STREAM;
      end
      rq.row = (n != 0 && $urandom_range(9) != 0) ? 4'($urandom_range(n - 1))
                                                  : 4'($urandom_range(15));
      rq.col = (n != 0 && $urandom_range(9) != 0) ? 4'($urandom_range(n - 1))
                                                  : 4'($urandom_range(15));
      if (rq.func == amstore_pkg::FUNC_INSERT && $urandom_range(9) != 0)
         rq.label = 5'($urandom_range(n));
      else if ((rq.func == amstore_pkg::FUNC_DELETE ||
                rq.func == amstore_pkg::FUNC_ROW_STREAM) && n != 0
               && $urandom_range(9) != 0)
         rq.label = 5'($urandom_range(n - 1));
      else
         rq.label = 5'($urandom_range(16));
      case ($urandom_range(15))
         0:       rq.weight = 32'h8000_0000;
         1:       rq.weight = 32'h7FFF_FFFF;
         2:       rq.weight = 32'h0000_0000;
         3:       rq.weight = 32'hFFFF_FFFF;
         default: rq.weight = $urandom;
      endcase
      return rq;
   endfunction

   task automatic push_request(input request_type rq, input logic typed,
                               input logic [1:0] typed_status, input logic [4:0] typed_total);
      response_type words[$];
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= rq.func;
      req_row_vertex   <= rq.row;
      req_col_vertex   <= rq.col;
      req_vertex_label <= rq.label;
      req_edge_weight  <= rq.weight;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
      apply_request(rq, words);
      if (typed) begin
         words.delete();
         words.push_back(response_type'{typed_status, 32'd0, 1'b0, 4'd0, typed_total, 1'b1});
      end
      foreach (words[i]) awaited_words.push_back(words[i]);
   endtask

   task automatic write_mode(input logic directed);
      csr_write_enable <= 1'b1;
      csr_write_data   <= directed;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      graph_directed = directed;
   endtask

   task automatic wait_drained();
      while (awaited_words.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h, got %h", $time, what, want, got);
         mismatches++;
      end
   endtask

   task automatic check_response_word();
      response_type want;
      if (awaited_words.size() == 0) begin
         $display("%0t: unexpected word, status %h weight %h last %b", $time,
                  rsp_status, rsp_weight_out, rsp_last);
         mismatches++;
      end else begin
         want = awaited_words.pop_front();
         check_field("status", 32'(want.status), 32'(rsp_status));
         check_field("weight_out", want.weight, rsp_weight_out);
         check_field("is_adjacent", 32'(want.adjacent), 32'(rsp_is_adjacent));
         check_field("column_index", 32'(want.column), 32'(rsp_column_index));
         check_field("vertex_total", 32'(want.total), 32'(rsp_vertex_total));
         check_field("last", 32'(want.last), 32'(rsp_last));
         words_checked++;
         if (want.status == amstore_pkg::STATUS_RANGE) range_words++;
         if (want.status == amstore_pkg::STATUS_FULL) full_words++;
      end
   endtask

   // result side: take a word when offered, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_response_word();
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   initial begin
      #(20_000_000);
      $display("%0t: run did not finish in time", $time);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      request_type rq;
      int unsigned spins;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_func         <= amstore_pkg::FUNC_SET_EDGE;
      req_row_vertex   <= 4'd0;
      req_col_vertex   <= 4'd0;
      req_vertex_label <= 5'd0;
      req_edge_weight  <= 32'sd0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= 1'b0;
      for (int r = 0; r < NV; r++)
         for (int c = 0; c < NV; c++) graph_weight[r][c] = 32'd0;
      graph_order = 0;
      graph_directed = 1'b0;

      dir_table = '{
         // empty graph: accesses and a label past the end are out of range, an unused code is OK; then three inserts
         '{amstore_pkg::FUNC_READ_EDGE, 4'd0, 4'd0, 5'd0, 32'h0000_0000,
           1'b1, amstore_pkg::STATUS_RANGE, 5'd0},
         '{amstore_pkg::FUNC_ROW_STREAM, 4'd0, 4'd0, 5'd0, 32'h0000_0000,
           1'b1, amstore_pkg::STATUS_RANGE, 5'd0},
         '{amstore_pkg::FUNC_DELETE, 4'd0, 4'd0, 5'd0, 32'h0000_0000,
           1'b1, amstore_pkg::STATUS_RANGE, 5'd0},
         '{amstore_pkg::FUNC_INSERT, 4'd0, 4'd0, 5'd1, 32'h0000_0000,
           1'b1, amstore_pkg::STATUS_RANGE, 5'd0},
         '{FUNC_UNUSED, 4'd15, 4'd15, 5'd16, 32'hFFFF_FFFF,
           1'b1, amstore_pkg::STATUS_OK, 5'd0},
         '{amstore_pkg::FUNC_INSERT, 4'd0, 4'd0, 5'd0, 32'h0000_0000,
           1'b1, amstore_pkg::STATUS_OK, 5'd1},
         '{amstore_pkg::FUNC_INSERT, 4'd0, 4'd0, 5'd1, 32'h0000_0000,
           1'b1, amstore_pkg::STATUS_OK, 5'd2},
         '{amstore_pkg::FUNC_INSERT, 4'd0, 4'd0, 5'd0, 32'h0000_0000,
           1'b1, amstore_pkg::STATUS_OK, 5'd3},
         // undirected: mirrored write, then a self loop
         '{amstore_pkg::FUNC_SET_EDGE, 4'd0, 4'd2, 5'd0, 32'h7FFF_FFFF,
           1'b1, amstore_pkg::STATUS_OK, 5'd3},
         '{amstore_pkg::FUNC_SET_EDGE, 4'd1, 4'd1, 5'd0, 32'h8000_0000,
           1'b1, amstore_pkg::STATUS_OK, 5'd3},
         '{amstore_pkg::FUNC_READ_EDGE, 4'd2, 4'd0, 5'd0, 32'h0000_0000,
           1'b0, amstore_pkg::STATUS_OK, 5'd0},
         '{amstore_pkg::FUNC_ADJ_TEST, 4'd1, 4'd1, 5'd0, 32'h0000_0000,
           1'b0, amstore_pkg::STATUS_OK, 5'd0},
         '{amstore_pkg::FUNC_ROW_STREAM, 4'd0, 4'd0, 5'd2, 32'h0000_0000,
           1'b0, amstore_pkg::STATUS_OK, 5'd0},
         '{amstore_pkg::FUNC_SET_EDGE, 4'd15, 4'd0, 5'd0, 32'h0001_0000,
           1'b1, amstore_pkg::STATUS_RANGE, 5'd3},
         '{amstore_pkg::FUNC_ADJ_TEST, 4'd0, 4'd15, 5'd0, 32'h0000_0000,
           1'b1, amstore_pkg::STATUS_RANGE, 5'd3},
         '{amstore_pkg::FUNC_CLEAR_EDGE, 4'd0, 4'd2, 5'd0, 32'h1234_5678,
           1'b1, amstore_pkg::STATUS_OK, 5'd3},
         '{amstore_pkg::FUNC_ADJ_TEST, 4'd2, 4'd0, 5'd0, 32'h0000_0000,
           1'b0, amstore_pkg::STATUS_OK, 5'd0},
         // append at the end, then a label past it
         '{amstore_pkg::FUNC_INSERT, 4'd0, 4'd0, 5'd3, 32'h0000_0000,
           1'b1, amstore_pkg::STATUS_OK, 5'd4},
         '{amstore_pkg::FUNC_INSERT, 4'd0, 4'd0, 5'd16, 32'h0000_0000,
           1'b1, amstore_pkg::STATUS_RANGE, 5'd4},
         '{amstore_pkg::FUNC_SET_EDGE, 4'd3, 4'd1, 5'd0, 32'hFFFF_FFFF,
           1'b0, amstore_pkg::STATUS_OK, 5'd0},
         '{amstore_pkg::FUNC_INSERT, 4'd0, 4'd0, 5'd1, 32'h0000_0000,
           1'b0, amstore_pkg::STATUS_OK, 5'd0},
         '{amstore_pkg::FUNC_ROW_STREAM, 4'd0, 4'd0, 5'd4, 32'h0000_0000,
           1'b0, amstore_pkg::STATUS_OK, 5'd0},
         '{amstore_pkg::FUNC_DELETE, 4'd0, 4'd0, 5'd0, 32'h0000_0000,
           1'b0, amstore_pkg::STATUS_OK, 5'd0},
         '{amstore_pkg::FUNC_DELETE, 4'd0, 4'd0, 5'd15, 32'h0000_0000,
           1'b1, amstore_pkg::STATUS_RANGE, 5'd4},
         '{amstore_pkg::FUNC_ROW_STREAM, 4'd0, 4'd0, 5'd16, 32'h0000_0000,
           1'b1, amstore_pkg::STATUS_RANGE, 5'd4},
         '{amstore_pkg::FUNC_READ_EDGE, 4'd3, 4'd0, 5'd0, 32'h0000_0000,
           1'b0, amstore_pkg::STATUS_OK, 5'd0}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      write_mode(1'b0);

      for (int i = 0; i < $size(dir_table); i++) begin
         rq = '{dir_table[i].func, dir_table[i].row, dir_table[i].col,
                dir_table[i].label, dir_table[i].weight};
         push_request(rq, dir_table[i].typed, dir_table[i].status, dir_table[i].total);
      end

      for (int ph = 0; ph < 4; ph++) begin
         // mode only changes with the block idle
         req_valid <= 1'b0;
         wait_drained();
         write_mode(phase_mode[ph]);
         req_idle_pct = phase_idle[ph];
         rsp_idle_pct = phase_idle[ph];
         for (int i = 0; i < phase_items[ph]; i++)
            push_request(random_request(phase_target[ph]), 1'b0, amstore_pkg::STATUS_OK,
                         5'd0);
      end
      req_valid <= 1'b0;

      spins = 0;
      while (awaited_words.size() != 0 && spins < 100000) begin
         @(posedge clock);
         spins++;
      end
      repeat (64) @(posedge clock);
      if (awaited_words.size() != 0) begin
         $display("%0t: %0d expected words never arrived", $time, awaited_words.size());
         mismatches++;
      end

      $display("%0d requests over both graph modes, %0d response words checked",
               requests_sent, words_checked);
      $display("%0d words flagged out of range, %0d inserts refused on a full store",
               range_words, full_words);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
